// ===== rtl/dla_pkg.sv =====
// ----------------------------------------------------------------------------
// dla_pkg: shared types and constants of the decimated level averager
// Holds the operation codes, the request structure passed between the input
// register and the level core, and the constants of the averaging arithmetic.
// ----------------------------------------------------------------------------
package dla_pkg;

    // Number of taken samples that make up one average.
    localparam int AVG_SAMPLES = 10;

    // Spacing between taken samples: base plus the low bits of the taken sample.
    localparam int STRIDE_BASE = 80;
    localparam int STRIDE_BITS = 5;

    // Widths of the running state.
    localparam int SUM_W   = 11;
    localparam int COUNT_W = 4;
    localparam int SKIP_W  = 7;
    localparam int LEVEL_W = 8;

    // Division of the running sum by AVG_SAMPLES as a multiplication by a
    // rounded-up reciprocal. With a sum below 2**SUM_W and AVG_SAMPLES at most
    // 15 the error stays below one unit for a shift of 20.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int AVG_RECIP   = ((2 ** RECIP_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_INIT   = 2'd1,
        OP_CLOSE  = 2'd2
    } dla_op_e;

    // One request as held in the input register.
    typedef struct packed {
        logic [1:0]        op;
        logic signed [7:0] sample;
        logic              frame_start;
    } dla_item_t;

endpackage

// ===== rtl/dla_in_reg.sv =====
// ----------------------------------------------------------------------------
// dla_in_reg: input register of the decimated level averager
// Captures one request per cycle while it is free and holds it until the level core takes it.
// ----------------------------------------------------------------------------
module dla_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dla_pkg::dla_item_t in_item,
    input  logic               item_take,
    output logic               item_valid,
    output dla_pkg::dla_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    dla_pkg::dla_item_t item_reg;

    // The register is free when empty or when its request leaves this cycle.
    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    // Control bit under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded without reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/dla_core.sv =====
// ----------------------------------------------------------------------------
// dla_core: level tracking state and result register
// Updates the running sum, count and skip state for one request per cycle
// while the result register can take it, and writes the level and update flag into the result register.
// ----------------------------------------------------------------------------
module dla_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  dla_pkg::dla_item_t                  item,
    output logic                                item_take,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dla_pkg::LEVEL_W-1:0]         mouth_level,
    output logic                                level_updated
);

    logic [dla_pkg::SUM_W-1:0]   sum_reg,   sum_next;
    logic [dla_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [dla_pkg::SKIP_W-1:0]  skip_reg,  skip_next;
    logic                        full_reg,  full_next;
    logic [dla_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic                        out_valid_reg, out_valid_next;
    logic [dla_pkg::LEVEL_W-1:0] res_level_reg;
    logic                        res_updated_reg;
    logic                        updated;

    logic [7:0]                  magnitude;
    logic [dla_pkg::SUM_W-1:0]   sum_inc;
    logic [dla_pkg::COUNT_W-1:0] count_inc;
    logic [dla_pkg::SKIP_W-1:0]  skip_taken;
    logic [dla_pkg::PROD_W-1:0]  product;
    logic [dla_pkg::LEVEL_W-1:0] quotient;
    logic                        skip_cur;
    logic                        full_cur;

    // A request moves on when the result register is empty or being emptied.
    assign item_take = item_valid && (!out_valid_reg || out_ready);

    // Absolute value of the sample; the most negative code gives 128.
    assign magnitude = item.sample[7] ? (~item.sample + 8'd1) : item.sample;

    assign sum_inc   = sum_reg + {{(dla_pkg::SUM_W - 8){1'b0}}, magnitude};
    assign count_inc = count_reg + {{(dla_pkg::COUNT_W - 1){1'b0}}, 1'b1};

    // Distance to the next taken sample, less the one being taken now.
    assign skip_taken = dla_pkg::SKIP_W'(dla_pkg::STRIDE_BASE - 1)
                      + {{(dla_pkg::SKIP_W - dla_pkg::STRIDE_BITS){1'b0}},
                         item.sample[dla_pkg::STRIDE_BITS-1:0]};

    // Sum divided by the averaging length through the reciprocal.
    assign product  = {{dla_pkg::RECIP_W{1'b0}}, sum_inc}
                    * dla_pkg::PROD_W'(dla_pkg::AVG_RECIP);
    assign quotient = product[dla_pkg::RECIP_SHIFT +: dla_pkg::LEVEL_W];

    // A frame start clears the skip distance and the frame-full flag first.
    assign skip_cur = item.frame_start ? 1'b0 : (skip_reg != '0);
    assign full_cur = item.frame_start ? 1'b0 : full_reg;

    // Next state for the request under way.
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        full_next  = full_reg;
        level_next = level_reg;
        updated    = 1'b0;
        case (item.op)
            dla_pkg::OP_INIT:
            begin
                level_next = '0;
                sum_next   = '0;
                count_next = '0;
            end
            dla_pkg::OP_CLOSE:
            begin
                level_next = '0;
            end
            dla_pkg::OP_SAMPLE:
            begin
                if (item.frame_start)
                begin
                    skip_next = '0;
                    full_next = 1'b0;
                end
                if (!full_cur)
                begin
                    if (!skip_cur)
                    begin
                        sum_next   = sum_inc;
                        count_next = count_inc;
                        skip_next  = skip_taken;
                        if (count_inc >= dla_pkg::COUNT_W'(dla_pkg::AVG_SAMPLES))
                        begin
                            level_next = quotient;
                            sum_next   = '0;
                            count_next = '0;
                            full_next  = 1'b1;
                            updated    = 1'b1;
                        end
                    end
                    else
                    begin
                        skip_next = skip_reg - {{(dla_pkg::SKIP_W - 1){1'b0}}, 1'b1};
                    end
                end
            end
            default:
            begin
                // Unused code: state is kept and the level is reported.
            end
        endcase
    end

    // Result register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Tracking state and result occupancy under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            skip_reg      <= '0;
            full_reg      <= 1'b0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                skip_reg  <= skip_next;
                full_reg  <= full_next;
                level_reg <= level_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            res_level_reg   <= level_next;
            res_updated_reg <= updated;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mouth_level   = res_level_reg;
    assign level_updated = res_updated_reg;

endmodule

// ===== rtl/decimated_level_averager_unit.sv =====
// ----------------------------------------------------------------------------
// decimated_level_averager_unit: loudness tracker for mouth animation
// Averages the magnitude of decimated 8-bit audio samples per playback frame.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with op, sample and frame_start.
//   Op 0 feeds an audio sample, op 1 clears level, sum and count, op 2
//   clears the level only. Every request gives exactly one result on
//   out_valid/out_ready carrying mouth_level and level_updated.
//   An accepted request is held in the input register, and its result is
//   written into the result register when the core takes it, where
//   out_valid shows it. Throughput is one request per cycle while the
//   receiver keeps up, set by the combinational update of the level state
//   between the two registers.
//   When the receiver stalls, the result register holds its result and the
//   input register still takes one more request; after that in_ready drops
//   until the result is taken.
//   Reset clears the level, running sum, count, skip distance and frame
//   flag, and empties both registers; in_ready is high straight after.
// ----------------------------------------------------------------------------
module decimated_level_averager_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic signed [7:0] sample,
    input  logic              frame_start,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        mouth_level,
    output logic              level_updated
);

    dla_pkg::dla_item_t in_item;
    dla_pkg::dla_item_t item;
    logic               item_valid;
    logic               item_take;

    assign in_item.op          = op;
    assign in_item.sample      = sample;
    assign in_item.frame_start = frame_start;

    // Input register.
    dla_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Level state and result register.
    dla_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mouth_level   (mouth_level),
        .level_updated (level_updated)
    );

    // An empty result register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low while no result is pending");

    // A fresh average never exceeds the largest magnitude.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && level_updated) |-> (mouth_level <= 8'd128))
        else $error("averaged level out of range");

    // Accepting while the output is stalled fills the input register.
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_valid && !out_ready) |=> !in_ready || out_ready)
        else $error("input register overrun under output stall");

endmodule

// ===== sim/level_average_checker.sv =====
// ----------------------------------------------------------------------------
// level_average_checker: result checker for the decimated level averager
// Watches the request and result channels of the block, keeps its own copy of the
// averaging state, works out the level and update flag that each accepted
// request should produce and compares them with the results as they leave.
// ----------------------------------------------------------------------------
module level_average_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        op,
    input  logic signed [7:0] sample,
    input  logic              frame_start,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [7:0]        mouth_level,
    input  logic              level_updated,
    output int                pending_levels,
    output int                mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import dla_pkg::*;

    // One result as the block should report it.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               updated;
    } level_result_t;

    // Own copy of the averaging state.
    logic [SUM_W-1:0]   acc_sum;
    logic [COUNT_W-1:0] acc_count;
    logic [SKIP_W-1:0]  gap_left;
    logic               frame_done;
    logic [LEVEL_W-1:0] level_now;

    // Results still owed by the block, oldest first.
    level_result_t expected_levels[$];

    // Applies one request to the state and returns the result that it causes.
    function automatic level_result_t advance_level(input logic [1:0] code,
                                                    input logic signed [7:0] smp,
                                                    input logic fs);
        level_result_t res;
        logic [8:0]    magnitude;
        res.updated = 1'b0;
        // The most negative sample has a magnitude of 128, so nine bits are needed.
        magnitude = smp[7] ? 9'(-int'(smp)) : {1'b0, smp};
        case (code)
            OP_INIT:
            begin
                level_now = '0;
                acc_sum   = '0;
                acc_count = '0;
            end
            OP_CLOSE:
            begin
                level_now = '0;
            end
            OP_SAMPLE:
            begin
                // A new frame always takes its first sample.
                if (fs)
                begin
                    gap_left   = '0;
                    frame_done = 1'b0;
                end
                if (!frame_done)
                begin
                    if (gap_left == '0)
                    begin
                        acc_sum   = acc_sum + SUM_W'(magnitude);
                        acc_count = acc_count + 1'b1;
                        gap_left  = SKIP_W'(STRIDE_BASE + int'(smp[STRIDE_BITS-1:0]) - 1);
                        if (acc_count >= AVG_SAMPLES)
                        begin
                            level_now   = LEVEL_W'(int'(acc_sum) / AVG_SAMPLES);
                            acc_sum     = '0;
                            acc_count   = '0;
                            frame_done  = 1'b1;
                            res.updated = 1'b1;
                        end
                    end
                    else
                    begin
                        gap_left = gap_left - 1'b1;
                    end
                end
            end
            default:
            begin
                // The spare op code leaves everything as it is.
            end
        endcase
        res.level = level_now;
        return res;
    endfunction

    // Results are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin : watch
        level_result_t want;
        if (!rst_n)
        begin
            acc_sum        = '0;
            acc_count      = '0;
            gap_left       = '0;
            frame_done     = 1'b0;
            level_now      = '0;
            mismatch_count = 0;
            expected_levels.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("result with none owed: mouth_level %0d, level_updated %0b",
                           mouth_level, level_updated);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (mouth_level !== want.level)
                    begin
                        $error("mouth_level: expected %0d, actual %0d", want.level, mouth_level);
                        mismatch_count++;
                    end
                    if (level_updated !== want.updated)
                    begin
                        $error("level_updated: expected %0b, actual %0b",
                               want.updated, level_updated);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_levels.push_back(advance_level(op, sample, frame_start));
            end
        end
        pending_levels = expected_levels.size();
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the decimated level averager
// Drives a directed set of requests covering the edge cases of the averaging,
// then random playback frames with stray operations mixed in, while the
// result side stalls on its own pattern. The checker beside the block does
// all prediction and comparison and reports the number of failures.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dla_pkg::*;

    localparam int CLK_HALF_NS      = 4;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_REQUESTS  = 1430;
    localparam int FLOOD_REQUESTS   = 24;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES     = 8;
    localparam int TIMEOUT_NS       = 3_200_000;

    // Op code that the package leaves unused; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Stall patterns of the result side.
    typedef enum int {
        RX_STREAM,
        RX_CHOPPY,
        RX_SLOW
    } rx_mode_e;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic signed [7:0] sample;
    logic              frame_start;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        mouth_level;
    logic              level_updated;

    int pending_levels;
    int mismatch_count;
    int hold_off_asked = 0;
    int frame_left = 0;

    decimated_level_averager_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .sample        (sample),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mouth_level   (mouth_level),
        .level_updated (level_updated)
    );

    level_average_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .sample         (sample),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mouth_level    (mouth_level),
        .level_updated  (level_updated),
        .pending_levels (pending_levels),
        .mismatch_count (mismatch_count)
    );

    // Clock generation.
    always
    begin
        #(CLK_HALF_NS) clk = ~clk;
    end

    // Offers one request and returns once it has been accepted.
    task automatic send_request(input logic [1:0] code, input logic signed [7:0] smp,
                                input logic fs);
        @(negedge clk);
        in_valid    <= 1'b1;
        op          <= code;
        sample      <= smp;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Leaves the request channel idle for a number of cycles.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Sends the next request of a random playback stream. Most requests are
    // samples of frames of mixed length; a few are init, close, the spare op
    // code or a frame start in the middle of a frame.
    task automatic send_random_request();
        int                pick;
        int                span_pick;
        logic [1:0]        code;
        logic signed [7:0] smp;
        logic              fs;
        pick = $urandom_range(0, 199);
        smp  = 8'($urandom);
        code = OP_SAMPLE;
        if (pick < 1)
            code = OP_INIT;
        else if (pick < 4)
            code = OP_CLOSE;
        else if (pick < 6)
            code = OP_UNUSED;
        if (code != OP_SAMPLE)
        begin
            fs = 1'($urandom);
        end
        else
        begin
            if (frame_left == 0)
            begin
                // Short frames take one sample each; longer ones can reach the stride.
                span_pick = $urandom_range(0, 99);
                if (span_pick < 80)
                    frame_left = $urandom_range(1, 4);
                else if (span_pick < 97)
                    frame_left = $urandom_range(40, 120);
                else
                    frame_left = $urandom_range(250, 400);
                fs = 1'b1;
            end
            else
            begin
                fs = (pick == 199);
            end
            frame_left--;
        end
        send_request(code, smp, fs);
    endtask

    // Result side: phases of steady, choppy and slow acceptance, plus a long
    // hold-off whenever the stimulus asks for one.
    initial
    begin : receiver
        rx_mode_e mode;
        int       span;
        int       served;
        served    = 0;
        out_ready = 1'b0;
        forever
        begin
            mode = rx_mode_e'($urandom_range(0, 2));
            span = $urandom_range(8, 60);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_off_asked != served)
                begin
                    served++;
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        RX_STREAM: out_ready <= 1'b1;
                        RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
                        default:   out_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int burst;
        int sent;
        bit flooded;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_SAMPLE;
        sample      = '0;
        frame_start = 1'b0;
        sent        = 0;
        flooded     = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Full-scale negative samples, one per frame, give the top level of 128.
        send_request(OP_INIT, 8'sh7F, 1'b1);
        repeat (AVG_SAMPLES) send_request(OP_SAMPLE, 8'sh80, 1'b1);
        // The frame is full, so this sample is ignored.
        send_request(OP_SAMPLE, 8'sh7F, 1'b0);
        send_request(OP_CLOSE, 8'sh80, 1'b1);
        send_request(OP_UNUSED, 8'sh01, 1'b1);
        // Largest positive sample sets the longest stride; the next one is skipped.
        send_request(OP_SAMPLE, 8'sh7F, 1'b1);
        send_request(OP_SAMPLE, 8'shFF, 1'b0);
        send_request(OP_SAMPLE, 8'sh00, 1'b1);
        send_request(OP_SAMPLE, 8'sh9F, 1'b1);
        // Init keeps the skip distance, so this sample is still skipped.
        send_request(OP_INIT, 8'sh00, 1'b0);
        send_request(OP_SAMPLE, 8'sh00, 1'b0);
        pause_sender(1);
        wait (pending_levels == 0);

        // Random frames in bursts, with one flood against a held-off receiver.
        while (sent < RANDOM_REQUESTS)
        begin
            if (!flooded && sent >= RANDOM_REQUESTS / 3)
            begin
                flooded = 1'b1;
                hold_off_asked <= hold_off_asked + 1;
                repeat (FLOOD_REQUESTS) send_random_request();
                sent += FLOOD_REQUESTS;
                pause_sender(1);
                wait (pending_levels == 0);
            end
            burst = $urandom_range(1, 40);
            repeat (burst) send_random_request();
            sent += burst;
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end

        pause_sender(1);
        wait (pending_levels == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_levels == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== decimated_level_averager_unit.f =====
rtl/dla_pkg.sv
rtl/dla_in_reg.sv
rtl/dla_core.sv
rtl/decimated_level_averager_unit.sv
sim/level_average_checker.sv
sim/testbench.sv
